[rtl/core/pbe_pkg.sv]
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared types, widths, codes and reset values of the pad button edge and
// auto-repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pbe_pkg;

    localparam int BTN_W    = 16;
    localparam int BITS_W   = 24;
    localparam int AXIS_W   = 8;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;
    localparam int COUNT_W  = 5;
    localparam int DIR_W    = 4;
    localparam int AMT_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 1;

    localparam int PORT_COUNT_DEFAULT = 2;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd400;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd40;
    localparam logic [DELAY_W-1:0] EARLY_EXTRA_RST   = 16'd43;
    localparam logic [COUNT_W-1:0] EARLY_COUNT_RST   = 5'd20;
    localparam logic [AXIS_W-1:0]  STICK_HIGH_RST    = 8'hbf;
    localparam logic [AXIS_W-1:0]  STICK_LOW_RST     = 8'h40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [AMT_W-1:0]   AMT_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_DELAY = 3'd0,
        CFG_REPEAT_DELAY  = 3'd1,
        CFG_EARLY_EXTRA   = 3'd2,
        CFG_EARLY_COUNT   = 3'd3,
        CFG_STICK_HIGH    = 3'd4,
        CFG_STICK_LOW     = 3'd5
    } cfg_reg_e;

    typedef enum logic [1:0] {
        LINK_NOT_READY = 2'd0,
        LINK_READ_FAIL = 2'd1,
        LINK_READ_OK   = 2'd2
    } link_status_e;

    localparam logic [1:0] KIND_NONE        = 2'd0;
    localparam logic [1:0] KIND_DUAL_ANALOG = 2'd2;

    localparam logic [DIR_W-1:0] DIR_NONE    = 4'd0;
    localparam logic [DIR_W-1:0] DIR_R_RIGHT = 4'd1;
    localparam logic [DIR_W-1:0] DIR_R_LEFT  = 4'd2;
    localparam logic [DIR_W-1:0] DIR_R_UP    = 4'd3;
    localparam logic [DIR_W-1:0] DIR_R_DOWN  = 4'd4;
    localparam logic [DIR_W-1:0] DIR_L_RIGHT = 4'd5;
    localparam logic [DIR_W-1:0] DIR_L_LEFT  = 4'd6;
    localparam logic [DIR_W-1:0] DIR_L_UP    = 4'd7;
    localparam logic [DIR_W-1:0] DIR_L_DOWN  = 4'd8;

    // Per-port repeat state held in the state memory.
    typedef struct packed {
        logic [BITS_W-1:0]  previous;
        logic [TIME_W-1:0]  deadline;
        logic [COUNT_W-1:0] count;
    } pbe_entry_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W:0]   b);
        logic [TIME_W+1:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = (sum[TIME_W+1:TIME_W] != 2'b00) ? '1 : sum[TIME_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/pbe_stick_map.sv]
// ----------------------------------------------------------------------------
// pbe_stick_map
// Maps the four stick axes to a direction code and amount, in priority order.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_stick_map
    import pbe_pkg::*;
(
    input  wire logic [AXIS_W-1:0] right_x,
    input  wire logic [AXIS_W-1:0] right_y,
    input  wire logic [AXIS_W-1:0] left_x,
    input  wire logic [AXIS_W-1:0] left_y,
    input  wire logic [AXIS_W-1:0] high_thr,
    input  wire logic [AXIS_W-1:0] low_thr,
    output logic      [DIR_W-1:0]  direction,
    output logic      [AMT_W-1:0]  amount
);

    function automatic logic [AMT_W-1:0] clamp_amt(input logic [AXIS_W-1:0] v);
        begin
            clamp_amt = (v > AXIS_W'(AMT_MAX)) ? AMT_MAX : v[AMT_W-1:0];
        end
    endfunction

    logic [AMT_W-1:0] rx_hi, rx_lo, ry_hi, ry_lo, lx_hi, lx_lo, ly_hi, ly_lo;

    assign rx_hi = clamp_amt(right_x - high_thr);
    assign rx_lo = clamp_amt(low_thr - right_x);
    assign ry_hi = clamp_amt(right_y - high_thr);
    assign ry_lo = clamp_amt(low_thr - right_y);
    assign lx_hi = clamp_amt(left_x - high_thr);
    assign lx_lo = clamp_amt(low_thr - left_x);
    assign ly_hi = clamp_amt(left_y - high_thr);
    assign ly_lo = clamp_amt(low_thr - left_y);

    // Vertical axes test the low side (up) before the high side (down).
    always_comb
    begin
        direction = DIR_NONE;
        amount    = '0;
        if (right_x >= high_thr)
        begin
            direction = DIR_R_RIGHT;
            amount    = rx_hi;
        end
        else if (right_x <= low_thr)
        begin
            direction = DIR_R_LEFT;
            amount    = rx_lo;
        end
        else if (right_y <= low_thr)
        begin
            direction = DIR_R_UP;
            amount    = ry_lo;
        end
        else if (right_y >= high_thr)
        begin
            direction = DIR_R_DOWN;
            amount    = ry_hi;
        end
        else if (left_x >= high_thr)
        begin
            direction = DIR_L_RIGHT;
            amount    = lx_hi;
        end
        else if (left_x <= low_thr)
        begin
            direction = DIR_L_LEFT;
            amount    = lx_lo;
        end
        else if (left_y <= low_thr)
        begin
            direction = DIR_L_UP;
            amount    = ly_lo;
        end
        else if (left_y >= high_thr)
        begin
            direction = DIR_L_DOWN;
            amount    = ly_hi;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pbe_state_mem.sv]
// ----------------------------------------------------------------------------
// pbe_state_mem
// Per-port repeat state memory: one write port, one registered read port,
// entry valid bits cleared by reset, and a bypass for a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_state_mem
    import pbe_pkg::*;
#(
    parameter int DEPTH = PORT_COUNT_DEFAULT,
    parameter int AW    = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output pbe_entry_t         rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire pbe_entry_t    wr_data
);

    pbe_entry_t           mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    pbe_entry_t           rd_data_reg;
    logic                 rd_valid_reg;
    pbe_entry_t           byp_data_reg;
    logic                 byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                // A write to the same entry in the read cycle wins over the array.
                byp_reg      <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = byp_reg      ? byp_data_reg :
                     rd_valid_reg ? rd_data_reg  : '0;

endmodule

`default_nettype wire

[rtl/core/pad_button_edge_repeat_unit.sv]
// ----------------------------------------------------------------------------
// pad_button_edge_repeat_unit
// Gamepad press-edge detector with typematic auto-repeat for several ports.
//
//  Channel   Direction  Word contents
//  s_axis    in         one poll of one port (buttons, axes, time; tuser: kind)
//  m_axis    out        press/held bit words, stick direction (tuser: read_ok)
//  cfg       in         register writes, no read-back
//
// One poll per cycle is accepted unless the output stalls; results are registered.
// Stage one reads the port's repeat state from the state memory and prepares
// the stick code and deadline sums; stage two updates state and writes back.
// A back-to-back poll of the same port is served by the memory bypass.
// Reset clears all state at once through the memory valid bits.
// A stalled output holds one result while one further poll is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_button_edge_repeat_unit
    import pbe_pkg::*;
#(
    parameter int PORT_COUNT = PORT_COUNT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // buttons[15:0], right_x[23:16], right_y[31:24], left_x[39:32],
    // left_y[47:40], now_ms[79:48]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0], port[1], link_status[3:2], pad_kind[5:4]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // port_pressed[23:0], port_held[47:24], all_pressed[71:48],
    // all_held[95:72], stick_direction[99:96], stick_amount[106:100], zeros
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // read_ok[0]
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    // Configuration registers.
    logic [DELAY_W-1:0] initial_delay_reg, repeat_delay_reg, early_extra_reg;
    logic [COUNT_W-1:0] early_count_reg;
    logic [AXIS_W-1:0]  stick_high_reg, stick_low_reg;
    logic [DELAY_W:0]   repeat_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_delay_reg <= INITIAL_DELAY_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
            early_extra_reg   <= EARLY_EXTRA_RST;
            early_count_reg   <= EARLY_COUNT_RST;
            stick_high_reg    <= STICK_HIGH_RST;
            stick_low_reg     <= STICK_LOW_RST;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INITIAL_DELAY: initial_delay_reg <= cfg_wdata;
                    CFG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_wdata;
                    CFG_EARLY_EXTRA:   early_extra_reg   <= cfg_wdata;
                    CFG_EARLY_COUNT:   early_count_reg   <= cfg_wdata[COUNT_W-1:0];
                    CFG_STICK_HIGH:    stick_high_reg    <= cfg_wdata[AXIS_W-1:0];
                    CFG_STICK_LOW:     stick_low_reg     <= cfg_wdata[AXIS_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    assign repeat_total = (DELAY_W+1)'(repeat_delay_reg) + (DELAY_W+1)'(early_extra_reg);

    // ---------------- stage one: capture, memory read, stateless work -------
    logic              in_mode, in_port;
    logic [1:0]        in_status, in_kind;
    logic [BTN_W-1:0]  in_btn;
    logic [TIME_W-1:0] in_now;
    logic              in_present;
    logic [PORT_W-1:0] in_port_idx;
    logic              in_accept;
    logic [DIR_W-1:0]  map_dir;
    logic [AMT_W-1:0]  map_amt;

    assign in_btn     = s_axis_tdata[15:0];
    assign in_now     = s_axis_tdata[79:48];
    assign in_mode    = s_axis_tuser[0];
    assign in_port    = s_axis_tuser[1];
    assign in_status  = s_axis_tuser[3:2];
    assign in_kind    = s_axis_tuser[5:4];
    assign in_present = (PORT_COUNT > 1) || !in_port;
    assign in_port_idx = in_present ? PORT_W'(in_port) : '0;
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    pbe_stick_map u_stick_map (
        .right_x   (s_axis_tdata[23:16]),
        .right_y   (s_axis_tdata[31:24]),
        .left_x    (s_axis_tdata[39:32]),
        .left_y    (s_axis_tdata[47:40]),
        .high_thr  (stick_high_reg),
        .low_thr   (stick_low_reg),
        .direction (map_dir),
        .amount    (map_amt)
    );

    logic              s1_valid_reg;
    logic              s1_mode_reg, s1_present_reg;
    logic [PORT_W-1:0] s1_port_reg;
    logic [1:0]        s1_status_reg, s1_kind_reg;
    logic [BTN_W-1:0]  s1_btn_reg;
    logic [TIME_W-1:0] s1_now_reg, s1_dl_init_reg, s1_dl_rep_reg, s1_dl_rep_ex_reg;
    logic [DIR_W-1:0]  s1_dir_reg;
    logic [AMT_W-1:0]  s1_amt_reg;

    logic s1_adv;
    logic out_valid_reg;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg      <= in_mode;
            s1_present_reg   <= in_present;
            s1_port_reg      <= in_port_idx;
            s1_status_reg    <= in_status;
            s1_kind_reg      <= in_kind;
            s1_btn_reg       <= in_btn;
            s1_now_reg       <= in_now;
            s1_dir_reg       <= map_dir;
            s1_amt_reg       <= map_amt;
            s1_dl_init_reg   <= sat_add(in_now, (TIME_W+1)'(initial_delay_reg));
            s1_dl_rep_reg    <= sat_add(in_now, (TIME_W+1)'(repeat_delay_reg));
            s1_dl_rep_ex_reg <= sat_add(in_now, (TIME_W+1)'(repeat_total));
        end
    end

    // ---------------- stage two: read-modify-write -------------------------
    pbe_entry_t ent_cur, ent_next;
    logic       mem_wr_en;

    pbe_state_mem #(
        .DEPTH (PORT_COUNT),
        .AW    (PORT_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_port_idx),
        .rd_data (ent_cur),
        .wr_en   (mem_wr_en),
        .wr_addr (s1_port_reg),
        .wr_data (ent_next)
    );

    logic [BITS_W-1:0] held_reg    [PORT_COUNT];
    logic [BITS_W-1:0] pressed_reg [PORT_COUNT];
    logic [BITS_W-1:0] held_next   [PORT_COUNT];
    logic [BITS_W-1:0] pressed_next[PORT_COUNT];
    logic [DIR_W-1:0]  last_dir_reg, last_dir_next;
    logic [AMT_W-1:0]  last_amt_reg, last_amt_next;

    logic              ready, ok, dual;
    logic [BITS_W-1:0] held_cur, h_new, p_new;
    logic [7:0]        dir_bits;
    logic              upd_bits;

    assign ready = ((s1_status_reg == LINK_READ_FAIL) || (s1_status_reg == LINK_READ_OK))
                 && (!s1_mode_reg || (s1_kind_reg != KIND_NONE));
    assign ok    = (s1_status_reg == LINK_READ_OK);
    assign dual  = (s1_kind_reg == KIND_DUAL_ANALOG);
    assign held_cur = held_reg[s1_port_reg];
    assign dir_bits = (s1_dir_reg == DIR_NONE) ? 8'h00
                    : (8'h01 << (s1_dir_reg - 4'd1));
    assign mem_wr_en = s1_adv && s1_present_reg;

    always_comb
    begin
        ent_next      = ent_cur;
        h_new         = held_cur;
        p_new         = pressed_reg[s1_port_reg];
        upd_bits      = 1'b0;
        last_dir_next = last_dir_reg;
        last_amt_next = last_amt_reg;
        if (s1_present_reg)
        begin
            if (!ready)
            begin
                p_new    = '0;
                upd_bits = 1'b1;
                if (s1_mode_reg)
                begin
                    ent_next.previous = '0;
                end
            end
            else if (ok && !s1_mode_reg)
            begin
                h_new             = {8'h00, ~s1_btn_reg};
                p_new             = h_new & ~ent_cur.previous;
                ent_next.previous = h_new;
                upd_bits          = 1'b1;
            end
            else if (ok)
            begin
                h_new = {held_cur[BITS_W-1:BTN_W], ~s1_btn_reg};
                if (dual)
                begin
                    last_dir_next = s1_dir_reg;
                    last_amt_next = s1_amt_reg;
                    h_new[BITS_W-1:BTN_W] = dir_bits;
                end
                p_new    = h_new & ~ent_cur.previous;
                upd_bits = 1'b1;
                if (ent_cur.previous == h_new)
                begin
                    // Unchanged word: repeat once the deadline has passed.
                    if (s1_now_reg > ent_cur.deadline)
                    begin
                        p_new             = h_new;
                        ent_next.deadline = (ent_cur.count < early_count_reg)
                                          ? s1_dl_rep_ex_reg : s1_dl_rep_reg;
                        if (ent_cur.count != COUNT_MAX)
                        begin
                            ent_next.count = ent_cur.count + COUNT_W'(1);
                        end
                    end
                end
                else
                begin
                    ent_next.count    = '0;
                    ent_next.deadline = s1_dl_init_reg;
                    ent_next.previous = h_new;
                end
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            held_next[p]    = held_reg[p];
            pressed_next[p] = pressed_reg[p];
            if (upd_bits && (PORT_W'(p) == s1_port_reg))
            begin
                held_next[p]    = h_new;
                pressed_next[p] = p_new;
            end
        end
    end

    logic [BITS_W-1:0] all_p, all_h;

    always_comb
    begin
        all_p = '0;
        all_h = '0;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            all_p = all_p | pressed_next[p];
            all_h = all_h | held_next[p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                held_reg[p]    <= '0;
                pressed_reg[p] <= '0;
            end
            last_dir_reg <= DIR_NONE;
            last_amt_reg <= '0;
        end
        else if (s1_adv)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                held_reg[p]    <= held_next[p];
                pressed_reg[p] <= pressed_next[p];
            end
            last_dir_reg <= last_dir_next;
            last_amt_reg <= last_amt_next;
        end
    end

    // ---------------- output register --------------------------------------
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= {5'd0, last_amt_next, last_dir_next, all_h, all_p,
                             s1_present_reg ? h_new : {BITS_W{1'b0}},
                             s1_present_reg ? p_new : {BITS_W{1'b0}}};
            out_ok_reg   <= s1_present_reg && ok;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ok_reg;

endmodule

`default_nettype wire

[rtl/core/pbe_checker.sv]
// ----------------------------------------------------------------------------
// pbe_checker
// Port-level checks of the pad button edge and auto-repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_checker
    import pbe_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

    // A result held back by the sink keeps its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // The polled port's bits are always part of the combined words.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[23:0] & ~m_axis_tdata[71:48]) == 24'd0)
                       && ((m_axis_tdata[47:24] & ~m_axis_tdata[95:72]) == 24'd0))
        else $error("port bits missing from combined bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[99:96] <= DIR_L_DOWN))
        else $error("stick direction out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[99:96] == DIR_NONE) |-> (m_axis_tdata[106:100] == '0))
        else $error("stick amount without direction");

    // At most one stick bit is held in the polled port's word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[47:40]))
        else $error("more than one stick bit held");

endmodule

bind pad_button_edge_repeat_unit pbe_checker u_pbe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[verif/pad_button_edge_repeat_unit_tb.sv]
// ----------------------------------------------------------------------------
// pad_button_edge_repeat_unit_tb
// Self-checking bench for the pad button edge and auto-repeat unit. Polls are
// driven on the input stream with random gaps, results are taken with random
// back-pressure, and every result word is compared field by field with the
// press, hold and stick state predicted by a scoreboard class. The run steps
// through several register settings, including both extremes.
// ----------------------------------------------------------------------------

module pad_button_edge_repeat_unit_tb;

    import pbe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 70;
    localparam int SETTING_COUNT = 6;

    // Codes that the input fields allow but the package leaves unnamed.
    localparam logic [1:0] KIND_DIGITAL   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN   = 2'd3;
    localparam logic [1:0] LINK_UNDEFINED = 2'd3;

    typedef struct {
        logic              mode;
        logic              port;
        logic [1:0]        link;
        logic [1:0]        kind;
        logic [BTN_W-1:0]  buttons;
        logic [AXIS_W-1:0] rx;
        logic [AXIS_W-1:0] ry;
        logic [AXIS_W-1:0] lx;
        logic [AXIS_W-1:0] ly;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    typedef struct {
        logic [BITS_W-1:0] port_pressed;
        logic [BITS_W-1:0] port_held;
        logic [BITS_W-1:0] all_pressed;
        logic [BITS_W-1:0] all_held;
        logic [DIR_W-1:0]  direction;
        logic [AMT_W-1:0]  amount;
        logic              read_ok;
    } press_report_t;

    class press_scoreboard;
        logic [DELAY_W-1:0] initial_delay;
        logic [DELAY_W-1:0] repeat_delay;
        logic [DELAY_W-1:0] early_extra;
        logic [COUNT_W-1:0] early_count;
        logic [AXIS_W-1:0]  stick_high;
        logic [AXIS_W-1:0]  stick_low;

        logic [BITS_W-1:0]  held [2];
        logic [BITS_W-1:0]  previous [2];
        logic [BITS_W-1:0]  pressed [2];
        logic [TIME_W-1:0]  deadline [2];
        logic [COUNT_W-1:0] repeats [2];
        logic [DIR_W-1:0]   last_dir;
        logic [AMT_W-1:0]   last_amt;

        press_report_t expected_reports [$];
        int errors;

        function new();
            initial_delay = INITIAL_DELAY_RST;
            repeat_delay  = REPEAT_DELAY_RST;
            early_extra   = EARLY_EXTRA_RST;
            early_count   = EARLY_COUNT_RST;
            stick_high    = STICK_HIGH_RST;
            stick_low     = STICK_LOW_RST;
            for (int i = 0; i < 2; i++)
            begin
                held[i]     = '0;
                previous[i] = '0;
                pressed[i]  = '0;
                deadline[i] = '0;
                repeats[i]  = '0;
            end
            last_dir = DIR_NONE;
            last_amt = '0;
            errors   = 0;
        endfunction

        function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_INITIAL_DELAY: initial_delay = value;
                CFG_REPEAT_DELAY:  repeat_delay  = value;
                CFG_EARLY_EXTRA:   early_extra   = value;
                CFG_EARLY_COUNT:   early_count   = value[COUNT_W-1:0];
                CFG_STICK_HIGH:    stick_high    = value[AXIS_W-1:0];
                CFG_STICK_LOW:     stick_low     = value[AXIS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function logic [TIME_W-1:0] add_clamped(logic [TIME_W-1:0] a,
                                                logic [DELAY_W-1:0] b);
            logic [TIME_W:0] sum;
            sum = {1'b0, a} + {17'b0, b};
            return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        endfunction

        function logic [AMT_W-1:0] clamp_amount(logic [AXIS_W-1:0] diff);
            return (diff > 8'd127) ? AMT_MAX : diff[AMT_W-1:0];
        endfunction

        // The first axis past a threshold wins, right stick before left stick.
        function void map_stick(poll_t p);
            last_amt = '0;
            if (p.rx >= stick_high)
            begin
                last_dir = DIR_R_RIGHT;
                last_amt = clamp_amount(p.rx - stick_high);
            end
            else if (p.rx <= stick_low)
            begin
                last_dir = DIR_R_LEFT;
                last_amt = clamp_amount(stick_low - p.rx);
            end
            else if (p.ry <= stick_low)
            begin
                last_dir = DIR_R_UP;
                last_amt = clamp_amount(stick_low - p.ry);
            end
            else if (p.ry >= stick_high)
            begin
                last_dir = DIR_R_DOWN;
                last_amt = clamp_amount(p.ry - stick_high);
            end
            else if (p.lx >= stick_high)
            begin
                last_dir = DIR_L_RIGHT;
                last_amt = clamp_amount(p.lx - stick_high);
            end
            else if (p.lx <= stick_low)
            begin
                last_dir = DIR_L_LEFT;
                last_amt = clamp_amount(stick_low - p.lx);
            end
            else if (p.ly <= stick_low)
            begin
                last_dir = DIR_L_UP;
                last_amt = clamp_amount(stick_low - p.ly);
            end
            else if (p.ly >= stick_high)
            begin
                last_dir = DIR_L_DOWN;
                last_amt = clamp_amount(p.ly - stick_high);
            end
            else
            begin
                last_dir = DIR_NONE;
            end
        endfunction

        function void note_poll(poll_t p);
            int                idx;
            bit                ready;
            bit                ok;
            logic [BITS_W-1:0] h;
            logic [TIME_W-1:0] dl;
            press_report_t     r;

            idx   = int'(p.port);
            ok    = (p.link == LINK_READ_OK);
            ready = (p.link == LINK_READ_FAIL || ok) && (!p.mode || p.kind != KIND_NONE);

            if (!ready)
            begin
                pressed[idx] = '0;
                if (p.mode)
                    previous[idx] = '0;
            end
            else if (ok && !p.mode)
            begin
                h             = {8'h00, ~p.buttons};
                held[idx]     = h;
                pressed[idx]  = h & ~previous[idx];
                previous[idx] = h;
            end
            else if (ok)
            begin
                h = {held[idx][BITS_W-1:BTN_W], ~p.buttons};
                if (p.kind == KIND_DUAL_ANALOG)
                begin
                    map_stick(p);
                    h[BITS_W-1:BTN_W] = '0;
                    if (last_dir != DIR_NONE)
                        h[int'(last_dir) + 15] = 1'b1;
                end
                held[idx]    = h;
                pressed[idx] = h & ~previous[idx];
                if (previous[idx] == h)
                begin
                    if (p.now_ms > deadline[idx])
                    begin
                        dl           = add_clamped(p.now_ms, repeat_delay);
                        pressed[idx] = h;
                        if (repeats[idx] < early_count)
                            dl = add_clamped(dl, early_extra);
                        if (repeats[idx] != COUNT_MAX)
                            repeats[idx]++;
                        deadline[idx] = dl;
                    end
                end
                else
                begin
                    repeats[idx]  = '0;
                    deadline[idx] = add_clamped(p.now_ms, initial_delay);
                    previous[idx] = h;
                end
            end

            r.port_pressed = pressed[idx];
            r.port_held    = held[idx];
            r.all_pressed  = pressed[0] | pressed[1];
            r.all_held     = held[0] | held[1];
            r.direction    = last_dir;
            r.amount       = last_amt;
            r.read_ok      = ok;
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
            if (got !== exp)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, exp, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] data,
                                   logic [OUT_USER_W-1:0] user);
            press_report_t e;
            if (expected_reports.size() == 0)
            begin
                $error("result word %0h arrived with no poll outstanding", data);
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            compare_field("port_pressed", 32'(e.port_pressed), 32'(data[23:0]));
            compare_field("port_held", 32'(e.port_held), 32'(data[47:24]));
            compare_field("all_pressed", 32'(e.all_pressed), 32'(data[71:48]));
            compare_field("all_held", 32'(e.all_held), 32'(data[95:72]));
            compare_field("stick_direction", 32'(e.direction), 32'(data[99:96]));
            compare_field("stick_amount", 32'(e.amount), 32'(data[106:100]));
            compare_field("padding", 32'd0, 32'(data[OUT_DATA_W-1:107]));
            compare_field("read_ok", 32'(e.read_ok), 32'(user[0]));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    press_scoreboard sb = new();

    bit                sender_quiet;
    bit                recv_quiet;
    logic [TIME_W-1:0] clock_ms [2];
    int                cycle_count;

    pad_button_edge_repeat_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Mostly no gap, some short ones and the odd long one.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic poll_t make_poll(logic mode, logic port, logic [1:0] link,
                                        logic [1:0] kind, logic [BTN_W-1:0] buttons,
                                        logic [AXIS_W-1:0] rx, logic [AXIS_W-1:0] ry,
                                        logic [AXIS_W-1:0] lx, logic [AXIS_W-1:0] ly,
                                        logic [TIME_W-1:0] now_ms);
        poll_t p;
        p.mode    = mode;
        p.port    = port;
        p.link    = link;
        p.kind    = kind;
        p.buttons = buttons;
        p.rx      = rx;
        p.ry      = ry;
        p.lx      = lx;
        p.ly      = ly;
        p.now_ms  = now_ms;
        return p;
    endfunction

    // Near the centre half of the time, otherwise pushed hard or anywhere.
    function automatic logic [AXIS_W-1:0] pick_axis();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (r == 1)
            return $urandom_range(0, 1) ? 8'd255 - 8'($urandom_range(0, 12))
                                        : 8'($urandom_range(0, 12));
        return 8'd118 + 8'($urandom_range(0, 20));
    endfunction

    task automatic send_poll(input poll_t p);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.now_ms, p.ly, p.lx, p.ry, p.rx, p.buttons};
        s_axis_tuser  <= {p.kind, p.link, p.port, p.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_poll(p);
    endtask

    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] vals [SETTING_COUNT]);
        cfg_reg_e order [SETTING_COUNT];
        order = '{CFG_INITIAL_DELAY, CFG_REPEAT_DELAY, CFG_EARLY_EXTRA,
                  CFG_EARLY_COUNT, CFG_STICK_HIGH, CFG_STICK_LOW};
        for (int i = 0; i < SETTING_COUNT; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.write_reg(order[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // A run of polls of one port with the same buttons held and time moving
    // on, so that edges and repeat deadlines are reached. Long runs are left
    // undisturbed to let the repeat count climb to its ceiling.
    task automatic run_burst(inout int sent);
        poll_t            p;
        logic [BTN_W-1:0] btn;
        logic [1:0]       kind;
        int               len;
        int               r;
        bit               clean;

        p.port = 1'($urandom_range(0, 1));
        p.mode = ($urandom_range(0, 7) != 0);
        r = $urandom_range(0, 9);
        kind = (r == 0) ? KIND_UNKNOWN : (r < 5) ? KIND_DIGITAL : KIND_DUAL_ANALOG;
        btn = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                          : 16'(~($urandom & $urandom & $urandom));
        p.rx = pick_axis();
        p.ry = pick_axis();
        p.lx = pick_axis();
        p.ly = pick_axis();
        clean = ($urandom_range(0, 4) == 0);
        len = clean ? $urandom_range(30, 60) : $urandom_range(2, 16);
        if ($urandom_range(0, 5) == 0)
            sender_quiet = !sender_quiet;
        if ($urandom_range(0, 14) == 0)
            clock_ms[p.port] = 32'hFFFF_FF00 | $urandom_range(0, 255);

        for (int i = 0; i < len; i++)
        begin
            clock_ms[p.port] += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2000)
                                                            : $urandom_range(0, 60);
            p.now_ms  = clock_ms[p.port];
            p.link    = LINK_READ_OK;
            p.kind    = kind;
            r = clean ? 99 : $urandom_range(0, 39);
            case (r)
                0: p.link = LINK_READ_FAIL;
                1: p.link = LINK_NOT_READY;
                2: p.link = LINK_UNDEFINED;
                3: p.kind = KIND_NONE;
                4: btn = 16'($urandom);
                5: p.rx = pick_axis();
                6: p.ly = pick_axis();
                default: ;
            endcase
            p.buttons = btn;
            send_poll(p);
            sent++;
        end
    endtask

    task automatic run_random_phase();
        int    sent;
        poll_t p;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                p = make_poll(1'($urandom), 1'($urandom), 2'($urandom), 2'($urandom),
                              16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), $urandom);
                send_poll(p);
                sent++;
            end
            else
            begin
                run_burst(sent);
            end
        end
    endtask

    // Result side: takes words with random back-pressure and checks them.
    initial
    begin
        int stall_left;
        stall_left = 0;
        recv_quiet = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_report(m_axis_tdata, m_axis_tuser);
            if ($urandom_range(0, 199) == 0)
                recv_quiet = !recv_quiet;
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap(recv_quiet);
            m_axis_tready <= (stall_left == 0) && rst_n;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] vals [SETTING_COUNT];

        sender_quiet = 1'b0;
        clock_ms[0]  = '0;
        clock_ms[1]  = '0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_INITIAL_DELAY;
        cfg_wdata     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed polls at the reset settings.
        send_poll(make_poll(0, 0, LINK_READ_OK, KIND_DIGITAL, 16'h0000, 128, 128, 128, 128, 0));
        send_poll(make_poll(0, 0, LINK_READ_OK, KIND_DIGITAL, 16'hFFFF, 128, 128, 128, 128, 10));
        send_poll(make_poll(0, 1, LINK_READ_OK, KIND_DIGITAL, 16'h00FF, 128, 128, 128, 128, 20));
        send_poll(make_poll(0, 1, LINK_READ_FAIL, KIND_DIGITAL, 16'h1234, 0, 0, 0, 0, 30));
        send_poll(make_poll(0, 1, LINK_NOT_READY, KIND_NONE, 16'h0F0F, 128, 128, 128, 128, 40));
        send_poll(make_poll(0, 0, LINK_UNDEFINED, KIND_DIGITAL, 16'hAAAA, 128, 128, 128, 128, 50));
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_NONE, 16'hFFFE, 128, 128, 128, 128, 60));
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_DIGITAL, 16'hFFFE, 128, 128, 128, 128, 100));
        // Deadline is 500: equal is not past, one more millisecond is.
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_DIGITAL, 16'hFFFE, 128, 128, 128, 128, 500));
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_DIGITAL, 16'hFFFE, 128, 128, 128, 128, 501));
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_UNKNOWN, 16'hFFFE, 0, 0, 0, 0, 600));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 255, 128, 128, 128, 700));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 0, 128, 128, 128, 710));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 0, 128, 128, 720));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 255, 128, 128, 730));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 128, 200, 128, 740));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 128, 64, 128, 750));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 128, 128, 10, 760));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 128, 128, 191, 770));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 255, 0, 0, 255, 780));
        send_poll(make_poll(1, 1, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h5555, 128, 128, 128, 128, 790));
        // Deadline sum runs past the top of the time range and sticks there.
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h0000, 128, 128, 128, 128,
                            32'hFFFF_FFF0));
        send_poll(make_poll(1, 0, LINK_READ_OK, KIND_DUAL_ANALOG, 16'h0000, 128, 128, 128, 128,
                            32'hFFFF_FFFF));
        send_poll(make_poll(1, 0, LINK_READ_FAIL, KIND_DUAL_ANALOG, 16'h1111, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, 0, LINK_READ_FAIL, KIND_NONE, 16'h1111, 0, 0, 0, 0, 0));

        run_random_phase();

        wait_drained(4);
        vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        apply_settings(vals);
        run_random_phase();

        // All ones: the count and threshold registers keep only their low bits.
        wait_drained(4);
        vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        apply_settings(vals);
        run_random_phase();

        // Short delays so that long runs saturate the repeat count.
        wait_drained(4);
        vals = '{16'd5, 16'd2, 16'd3, 16'd31, 16'd191, 16'd64};
        apply_settings(vals);
        run_random_phase();

        wait_drained(4);
        vals = '{16'($urandom_range(0, 600)), 16'($urandom_range(0, 100)),
                 16'($urandom_range(0, 100)), 16'($urandom_range(0, 31)),
                 16'($urandom_range(128, 255)), 16'($urandom_range(0, 127))};
        apply_settings(vals);
        run_random_phase();

        wait_drained(4);
        vals = '{INITIAL_DELAY_RST, REPEAT_DELAY_RST, EARLY_EXTRA_RST,
                 16'(EARLY_COUNT_RST), 16'(STICK_HIGH_RST), 16'(STICK_LOW_RST)};
        apply_settings(vals);
        run_random_phase();

        wait_drained(8);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
